### sv/rmc_pkg.sv
`timescale 1ns / 1ps
// rmc_pkg: character codes, tag text and field numbering for the RMC extractor.
// No dependencies.
package rmc_pkg;

  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;

  // "$GPRMC", first character in the top byte
  localparam logic [47:0] TAG_TEXT = "$GPRMC";

  localparam int NUM_FIELDS  = 6;
  localparam int MAX_RESULTS = 37;

  // field codes on the output
  localparam logic [2:0] FIELD_LAT     = 3'd0;
  localparam logic [2:0] FIELD_LAT_HEM = 3'd1;
  localparam logic [2:0] FIELD_LON     = 3'd2;
  localparam logic [2:0] FIELD_LON_HEM = 3'd3;
  localparam logic [2:0] FIELD_SPEED   = 3'd4;
  localparam logic [2:0] FIELD_VALID   = 3'd5;
  localparam logic [2:0] FIELD_NONE    = 3'd6;

  // Tokens 2..7 are kept in slots 0..5; field order is tokens 3,4,5,6,7,2.
  function automatic logic [2:0] slot_of(input logic [2:0] fld);
    logic [2:0] s;
    s = (fld == FIELD_VALID) ? 3'd0 : fld + 3'd1;
    return s;
  endfunction

endpackage

### sv/nmea_rmc_field_extractor_top.sv
`timescale 1ns / 1ps
// nmea_rmc_field_extractor_top: line store plus scan/emit sequencer for RMC sentences.
// Depends on rmc_pkg.
//
// Throughput: one byte word per cycle while a line is being collected.
// A CR/LF word starts a scan of the stored line, one memory read per byte over the
// single read port. If the tag was found, emit then tries each field code in a select
// step; per result it reads up to 4 bytes, then waits in the output handshake. No
// input word is taken during scan or emit.
// Reset: synchronous, clears the write position and the sequencer; the line store
// itself is not cleared and needs no clearing pass.
module nmea_rmc_field_extractor_top #(
  parameter int LINE_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] field_chars, [34:32] char_count, rest zero
  output logic [3:0]  m_axis_tuser,   // [2:0] field_code, [3] field_end
  output logic        m_axis_tlast    // last
);
  import rmc_pkg::*;

  localparam int AW = $clog2(LINE_BYTES);
  localparam int PW = $clog2(LINE_BYTES + 1);
  localparam logic [PW-1:0] LINE_LEN = PW'(LINE_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEL,
    ST_READ,
    ST_OUT
  } state_t;

  state_t state;

  // line store: written while collecting, read during scan and emit
  logic [7:0]    line_mem [LINE_BYTES];
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_addr;

  logic [PW-1:0] wp;
  logic [PW-1:0] wp_eff;
  logic          in_fire;
  logic          is_term;
  logic          is_print;

  // scan state
  logic [PW-1:0] line_len;
  logic [PW-1:0] pos;
  logic          rd_vld;
  logic [PW-1:0] rd_idx;
  logic [39:0]   tag_sr;
  logic          tag_hit;
  logic          tag_now;
  logic          in_tok;
  logic [3:0]    tok_cnt;
  logic [PW-1:0] cur_start;
  logic [PW-1:0] tok_start [NUM_FIELDS];
  logic [PW-1:0] tok_end   [NUM_FIELDS];
  logic [NUM_FIELDS-1:0] tok_vld;
  logic          issue_scan;
  logic          scan_done;
  logic          close_now;
  logic [PW-1:0] close_end;
  logic          rec_en;
  logic [2:0]    rec_slot;

  // emit state
  logic [2:0]    fld;
  logic [2:0]    cur_slot;
  logic [PW-1:0] p;
  logic [PW-1:0] e;
  logic [2:0]    icnt;
  logic [2:0]    ccnt;
  logic [31:0]   chars;
  logic [5:0]    n_res;
  logic          issue_emit;
  logic [NUM_FIELDS-1:0] fld_present;
  logic          later_present;

  // output word
  logic [31:0]   out_chars;
  logic [2:0]    out_cnt;
  logic [2:0]    out_code;
  logic          out_fend;
  logic          out_last;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign is_term  = (s_axis_tdata == CHAR_CR) || (s_axis_tdata == CHAR_LF);
  assign is_print = (s_axis_tdata >= CHAR_SPACE) && (s_axis_tdata <= CHAR_TILDE);
  // full store wraps before the byte is handled
  assign wp_eff   = (wp == LINE_LEN) ? '0 : wp;

  assign issue_scan = (state == ST_SCAN) && (pos != line_len);
  assign scan_done  = (state == ST_SCAN) && (pos == line_len) && !rd_vld;
  assign tag_now    = ({tag_sr, rd_data} == TAG_TEXT);

  // a token closes on a comma or at end of line
  assign close_now = (state == ST_SCAN) && in_tok &&
                     ((rd_vld && (rd_data == CHAR_COMMA)) || scan_done);
  assign close_end = rd_vld ? rd_idx : line_len;
  assign rec_en    = close_now && (tok_cnt >= 4'd2) && (tok_cnt <= 4'd7);
  assign rec_slot  = 3'(tok_cnt - 4'd2);

  assign cur_slot   = slot_of(fld);
  assign issue_emit = (state == ST_READ) && (icnt != 3'd4) && (p != e);

  // presence per field code; token 2 lands in the validity field
  assign fld_present = {tok_vld[0], tok_vld[NUM_FIELDS-1:1]};

  always_comb begin
    later_present = 1'b0;
    for (int g = 0; g < NUM_FIELDS; g++) begin
      if (fld_present[g] && (3'(g) > fld)) begin
        later_present = 1'b1;
      end
    end
  end

  assign rd_addr = (state == ST_READ) ? p[AW-1:0] : pos[AW-1:0];

  always_ff @(posedge clk) begin
    if (in_fire && is_print && !is_term) begin
      line_mem[wp_eff[AW-1:0]] <= s_axis_tdata;
    end
    rd_data <= line_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rec_en) begin
      tok_start[rec_slot] <= cur_start;
      tok_end[rec_slot]   <= close_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      wp      <= '0;
      rd_vld  <= 1'b0;
      tok_vld <= '0;
    end else begin
      if (rec_en) begin
        tok_vld[rec_slot] <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (is_term) begin
              line_len <= wp_eff;
              wp       <= '0;
              pos      <= '0;
              tag_sr   <= '0;
              tag_hit  <= 1'b0;
              in_tok   <= 1'b0;
              tok_cnt  <= '0;
              tok_vld  <= '0;
              rd_vld   <= 1'b0;
              state    <= ST_SCAN;
            end else if (is_print) begin
              wp <= wp_eff + 1'b1;
            end
          end
        end
        ST_SCAN: begin
          rd_vld <= issue_scan;
          rd_idx <= pos;
          if (issue_scan) begin
            pos <= pos + 1'b1;
          end
          if (rd_vld) begin
            tag_sr <= {tag_sr[31:0], rd_data};
            if (tag_now) begin
              tag_hit <= 1'b1;
            end
            if (rd_data == CHAR_COMMA) begin
              if (in_tok) begin
                in_tok <= 1'b0;
                if (tok_cnt != 4'd8) begin
                  tok_cnt <= tok_cnt + 4'd1;
                end
              end
            end else if (!in_tok) begin
              in_tok    <= 1'b1;
              cur_start <= rd_idx;
            end
          end
          if (scan_done) begin
            in_tok <= 1'b0;
            fld    <= FIELD_LAT;
            n_res  <= '0;
            state  <= tag_hit ? ST_SEL : ST_IDLE;
          end
        end
        ST_SEL: begin
          if (fld == FIELD_NONE) begin
            state <= ST_IDLE;
          end else if (tok_vld[cur_slot]) begin
            p      <= tok_start[cur_slot];
            e      <= tok_end[cur_slot];
            icnt   <= '0;
            ccnt   <= '0;
            chars  <= '0;
            rd_vld <= 1'b0;
            state  <= ST_READ;
          end else begin
            fld <= fld + 3'd1;
          end
        end
        ST_READ: begin
          rd_vld <= issue_emit;
          if (issue_emit) begin
            p    <= p + 1'b1;
            icnt <= icnt + 3'd1;
          end
          if (rd_vld) begin
            chars[ccnt[1:0]*8 +: 8] <= rd_data;
            ccnt <= ccnt + 3'd1;
          end
          if (!issue_emit && !rd_vld) begin
            out_chars <= chars;
            out_cnt   <= ccnt;
            out_code  <= fld;
            out_fend  <= (p == e);
            out_last  <= (n_res == 6'(MAX_RESULTS - 1)) || ((p == e) && !later_present);
            n_res     <= n_res + 6'd1;
            state     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            if (out_last) begin
              state <= ST_IDLE;
            end else if (out_fend) begin
              fld   <= fld + 3'd1;
              state <= ST_SEL;
            end else begin
              icnt  <= '0;
              ccnt  <= '0;
              chars <= '0;
              state <= ST_READ;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {5'd0, out_cnt, out_chars};
  assign m_axis_tuser  = {out_fend, out_code};
  assign m_axis_tlast  = out_last;

  // one line in flight: no input while a result word is pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");

  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    wp <= LINE_LEN)
    else $error("write position beyond line store");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_cnt >= 3'd1) && (out_cnt <= 3'd4) && (out_code < FIELD_NONE))
    else $error("bad result word");

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
    else $error("no return to idle after last word");

  a_result_limit: assert property (@(posedge clk) disable iff (rst)
    n_res == 6'(MAX_RESULTS) && m_axis_tvalid |-> m_axis_tlast)
    else $error("result limit passed without last");

endmodule
